### design/mbm_pkg.sv
package mbm_pkg;

  localparam int KNEE = 40;
  localparam int ADDR_W = 3;

  // Register index, taken from address bit 2
  localparam logic [0:0] IDX_RESERVED_MASK = 1'b0;
  localparam logic [7:0] RESERVED_MASK_RESET = 8'hF8;

  localparam logic [2:0] BUTTONS_RIGHT_ONLY = 3'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_RESERVED = 2'd2,
    ST_EXTRA    = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] buttons;
    logic [7:0] raw_x;
    logic [7:0] raw_y;
  } entry_t;

  localparam logic [7:0] CURVE [KNEE] = '{
    8'd1,  8'd1,  8'd2,  8'd2,  8'd3,  8'd4,  8'd5,  8'd6,
    8'd7,  8'd8,  8'd9,  8'd10, 8'd11, 8'd12, 8'd14, 8'd15,
    8'd17, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25,
    8'd26, 8'd28, 8'd29, 8'd30, 8'd32, 8'd33, 8'd34, 8'd35,
    8'd36, 8'd37, 8'd38, 8'd38, 8'd39, 8'd39, 8'd40, 8'd40
  };

  // Map a raw two's complement move onto the acceleration curve
  function automatic logic [7:0] shape(input logic [7:0] raw);
    logic signed [8:0] v;
    logic signed [8:0] t;
    logic signed [8:0] h;
    logic [7:0] m;
    logic [5:0] idx;
    logic [7:0] c;
    logic [7:0] r;
    v = $signed({raw[7], raw});
    m = raw[7] ? 8'(-raw) : raw;
    idx = m[5:0] - 6'd1;
    c = CURVE[idx];
    t = 9'sd0;
    h = 9'sd0;
    if (v < -9'sd40) begin
      // halve toward zero: bias negative values by one before the shift
      t = v + 9'sd40;
      h = (t + $signed({8'd0, t[8]})) >>> 1;
      r = h[7:0] - 8'd40;
    end else if (v > 9'sd40) begin
      t = v - 9'sd40;
      r = {1'b0, t[7:1]} + 8'd40;
    end else if (raw == 8'd0) begin
      r = 8'd0;
    end else begin
      r = raw[7] ? 8'(-c) : c;
    end
    return r;
  endfunction

endpackage

### design/mbm_front.sv
module mbm_front import mbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] reserved_button_mask,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] report_byte,
  input  logic       last_byte,
  output logic       push,
  output entry_t     push_entry,
  input  logic       push_ready
);

  logic [1:0] byte_position;
  logic [7:0] button_byte;
  logic [7:0] raw_x;
  logic [7:0] raw_y;
  logic       extra_seen;
  logic       take;
  logic [7:0] btn_final;
  logic [7:0] y_final;
  logic       extra_final;

  assign in_ready = push_ready;
  assign take     = in_valid && in_ready;
  assign push     = take && last_byte;

  // View of the report including the beat being taken now
  assign btn_final   = (byte_position == 2'd0) ? report_byte : button_byte;
  assign y_final     = (byte_position == 2'd2) ? report_byte : raw_y;
  assign extra_final = extra_seen || (byte_position == 2'd3 && report_byte != 8'd0);

  always_comb begin
    push_entry.buttons = btn_final[2:0];
    push_entry.raw_x   = raw_x;
    push_entry.raw_y   = y_final;
    priority if (byte_position < 2'd2) begin
      push_entry.status = ST_SHORT;
    end else if ((btn_final & reserved_button_mask) != 8'd0) begin
      push_entry.status = ST_RESERVED;
    end else if (extra_final) begin
      push_entry.status = ST_EXTRA;
    end else begin
      push_entry.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 2'd0;
      extra_seen    <= 1'b0;
      button_byte   <= 8'd0;
      raw_x         <= 8'd0;
      raw_y         <= 8'd0;
    end else if (take) begin
      unique case (byte_position)
        2'd0: button_byte <= report_byte;
        2'd1: raw_x <= report_byte;
        2'd2: raw_y <= report_byte;
        default: ;
      endcase
      if (last_byte) begin
        byte_position <= 2'd0;
        extra_seen    <= 1'b0;
      end else begin
        extra_seen <= extra_final;
        if (byte_position != 2'd3) begin
          byte_position <= byte_position + 2'd1;
        end
      end
    end
  end

endmodule

### design/mbm_queue.sv
module mbm_queue import mbm_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  entry_t wr_entry,
  output logic   rd_valid,
  input  logic   rd_ready,
  output entry_t rd_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_entry = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      priority if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end else begin
        count <= count;
      end
    end
  end

endmodule

### design/mbm_back.sv
module mbm_back import mbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_ready,
  input  entry_t     q_entry,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] report_status,
  output logic       click_valid,
  output logic       click_level,
  output logic       x_valid,
  output logic [7:0] x_move,
  output logic       y_valid,
  output logic [7:0] y_move
);

  logic       button_held;
  logic       click_locked;
  logic       lock_releasable;
  logic       button_held_next;
  logic       click_locked_next;
  logic       lock_releasable_next;
  logic       emit;
  logic       level;
  logic       any_btn;
  logic       right_only;
  logic       is_ok;
  logic       pop;
  logic [7:0] mx;
  logic [7:0] my;

  assign q_ready    = !out_valid || out_ready;
  assign pop        = q_valid && q_ready;
  assign is_ok      = (q_entry.status == ST_OK);
  assign any_btn    = (q_entry.buttons != 3'd0);
  assign right_only = (q_entry.buttons == BUTTONS_RIGHT_ONLY);
  assign mx         = shape(q_entry.raw_x);
  assign my         = shape(q_entry.raw_y);

  // Press / release / sticky right-click lock
  always_comb begin
    button_held_next     = button_held;
    click_locked_next    = click_locked;
    lock_releasable_next = lock_releasable;
    emit  = 1'b0;
    level = 1'b0;
    priority if (button_held && any_btn) begin
      emit = 1'b0;
    end else if (!button_held && !any_btn && !click_locked) begin
      emit = 1'b0;
    end else if (right_only && click_locked && !lock_releasable) begin
      emit = 1'b0;
    end else if (!button_held && !any_btn && click_locked) begin
      lock_releasable_next = 1'b1;
    end else if (button_held && !any_btn && !click_locked) begin
      button_held_next = 1'b0;
      emit  = 1'b1;
      level = 1'b0;
    end else if (!button_held && right_only && !click_locked) begin
      click_locked_next    = 1'b1;
      lock_releasable_next = 1'b0;
      emit  = 1'b1;
      level = 1'b1;
    end else if (!button_held && any_btn) begin
      click_locked_next = 1'b0;
      button_held_next  = 1'b1;
      emit  = 1'b1;
      level = 1'b1;
    end else begin
      emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      button_held     <= 1'b0;
      click_locked    <= 1'b0;
      lock_releasable <= 1'b1;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // leave the button machine untouched on a rejected report
      if (pop && is_ok) begin
        button_held     <= button_held_next;
        click_locked    <= click_locked_next;
        lock_releasable <= lock_releasable_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      report_status <= q_entry.status;
      click_valid   <= is_ok && emit;
      click_level   <= is_ok && emit && level;
      x_valid       <= is_ok && (mx != 8'd0);
      x_move        <= is_ok ? mx : 8'd0;
      y_valid       <= is_ok && (my != 8'd0);
      y_move        <= is_ok ? my : 8'd0;
    end
  end

endmodule

### design/mouse_boot_report_to_motion_top.sv
// Mouse boot-report converter. Report bytes stream in one beat per cycle, with
// last_byte set on the final byte; each report yields one result beat carrying
// a status (ok, too short, reserved button bit, nonzero extra byte) and, for a
// good report, an optional click level and the curve-shaped X and Y moves.
// A byte is taken every cycle while the report queue has room; a result is
// written into the queue on the edge that takes its last byte, loaded into the
// output register once that register is free, and leaves at up to one per
// cycle while out_ready is high. The queue of QUEUE_DEPTH reports absorbs
// output stalls before in_ready drops. The reserved-button mask sits at byte
// addresses 0 to 3 of the APB port (paddr[2] low) and resets to 0xF8; change it
// only while no report is in flight.
module mouse_boot_report_to_motion_top import mbm_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        report_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        report_status,
  output logic              click_valid,
  output logic              click_level,
  output logic              x_valid,
  output logic signed [7:0] x_move,
  output logic              y_valid,
  output logic signed [7:0] y_move
);

  logic [7:0] reserved_button_mask;
  logic       hit_mask;
  logic       push;
  logic       push_ready;
  entry_t     push_entry;
  logic       q_valid;
  logic       q_ready;
  entry_t     q_entry;
  logic [7:0] x_bits;
  logic [7:0] y_bits;

  assign pready   = 1'b1;
  assign hit_mask = (paddr[2] == IDX_RESERVED_MASK);
  assign prdata   = hit_mask ? {24'd0, reserved_button_mask} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_button_mask <= RESERVED_MASK_RESET;
    end else if (psel && penable && pwrite && pready && hit_mask) begin
      reserved_button_mask <= pwdata[7:0];
    end
  end

  mbm_front u_front (
    .clk                  (clk),
    .rst                  (rst),
    .reserved_button_mask (reserved_button_mask),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .report_byte          (report_byte),
    .last_byte            (last_byte),
    .push                 (push),
    .push_entry           (push_entry),
    .push_ready           (push_ready)
  );

  mbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_ready (push_ready),
    .wr_entry (push_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_entry (q_entry)
  );

  mbm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_entry       (q_entry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .report_status (report_status),
    .click_valid   (click_valid),
    .click_level   (click_level),
    .x_valid       (x_valid),
    .x_move        (x_bits),
    .y_valid       (y_valid),
    .y_move        (y_bits)
  );

  assign x_move = $signed(x_bits);
  assign y_move = $signed(y_bits);

endmodule
